>>> rtl/core/mexp_pkg.sv
// mexp_pkg: widths and packing constants shared by the modular exponent core
// and its serial modular multiplier. No dependencies.
package mexp_pkg;

  localparam int unsigned MOD_BITS = 31;
  localparam int unsigned EXP_BITS = 63;

  // exponent register also holds modulus-2 in inverse mode
  localparam int unsigned EXP_W = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;

  localparam int unsigned IN_DATA_W  = ((MOD_BITS + EXP_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((MOD_BITS + 7) / 8) * 8;

  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(64'd2147483647);

  localparam logic ACT_POWER   = 1'b0;
  localparam logic ACT_INVERSE = 1'b1;

  typedef logic [MOD_BITS-1:0] mod_t;
  typedef logic [EXP_W-1:0]    exp_t;

endpackage

>>> rtl/core/mexp_mulmod.sv
// mexp_mulmod: bit-serial modular multiplier, (a * b) mod m by double-and-add,
// one multiplier bit per cycle, msb first. Depends on mexp_pkg.
module mexp_mulmod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mexp_pkg::mod_t a_i,   // must be below m_i
  input  mexp_pkg::mod_t b_i,
  input  mexp_pkg::mod_t m_i,   // held stable while busy, at least 2
  output logic           done_o,
  output mexp_pkg::mod_t prod_o
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MOD_BITS);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  mod_t             acc_q, acc_d;
  mod_t             a_q, a_d;
  mod_t             bsh_q, bsh_d;
  mod_t             dbl;
  logic             last;

  // (x + y) mod m for x, y below m
  function automatic mod_t add_mod(mod_t x, mod_t y, mod_t m);
    logic [MOD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_BITS-1:0];
  endfunction

  assign last = (cnt_q == CNT_W'(MOD_BITS - 1));
  assign dbl  = add_mod(acc_q, acc_q, m_i);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    bsh_d  = bsh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      a_d    = a_i;
      bsh_d  = b_i;
    end else if (busy_q) begin
      acc_d = bsh_q[MOD_BITS-1] ? add_mod(dbl, a_q, m_i) : dbl;
      bsh_d = {bsh_q[MOD_BITS-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    bsh_q <= bsh_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiplier started while busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("done without a finished run");

  a_busy_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !last && !start_i) |=> busy_q) else $error("run ended early");

endmodule

>>> rtl/core/modular_exponent_and_inverse_core.sv
// modular_exponent_and_inverse_core: base^exponent mod modulus by right-to-left
// square-and-multiply, or the Fermat inverse. Depends on mexp_pkg, mexp_mulmod.
//
//  channel   dir  signals                           contents
//  s_axis    in   tvalid tready tdata tuser         tuser: action, tdata: base, exponent
//  m_axis    out  tvalid tready tdata               tdata: result
//  cfg       in   cfg_valid_i cfg_ready_o cfg_data_i modulus register write
//
//  one item at a time through the shared serial multiplier; a zero effective exponent or a
//  modulus below 2 skips the multiplier and goes straight to the result. a request is
//  taken while the last result still waits on m_axis; a finished item then holds until
//  the output register frees.
//  reset gives modulus 2^31-1 and an empty output; no clearing pass.
module modular_exponent_and_inverse_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mexp_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // base, exponent, zero pad
  input  logic                            s_axis_tuser,   // action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mexp_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // result, zero pad
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  mexp_pkg::mod_t                  cfg_data_i
);
  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_STEP = 3'd2;
  localparam logic [2:0] ST_MULA = 3'd3;
  localparam logic [2:0] ST_SQR  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  mod_t       modulus_q;
  exp_t       e_q, e_d;
  mod_t       b_q, b_d;
  mod_t       acc_q, acc_d;
  mod_t       res_q;
  logic       out_valid_q, out_valid_d;

  logic  in_acc, load;
  logic  mod_lt2;
  logic  act;
  mod_t  base_in;
  exp_t  exp_in, e_eff;
  logic  mul_start, mul_done;
  mod_t  mul_a, mul_b, mul_p;

  assign act     = s_axis_tuser;
  assign base_in = s_axis_tdata[MOD_BITS-1:0];
  assign exp_in  = EXP_W'(s_axis_tdata[MOD_BITS +: EXP_BITS]);
  assign mod_lt2 = (modulus_q[MOD_BITS-1:1] == '0);
  assign e_eff   = (act == ACT_INVERSE) ? (EXP_W'(modulus_q) - EXP_W'(2)) : exp_in;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d   = state_q;
    e_d       = e_q;
    b_d       = b_q;
    acc_d     = acc_q;
    mul_start = 1'b0;
    mul_a     = b_q;
    mul_b     = b_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          e_d   = e_eff;
          acc_d = MOD_BITS'(1);
          priority if (act == ACT_INVERSE && mod_lt2) begin
            state_d = ST_DONE;
          end else if (e_eff == '0) begin
            state_d = ST_DONE;
          end else if (mod_lt2) begin
            acc_d   = '0;
            state_d = ST_DONE;
          end else begin
            // base mod m as 1 * base through the multiplier
            mul_start = 1'b1;
            mul_a     = MOD_BITS'(1);
            mul_b     = base_in;
            state_d   = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_done) begin
          b_d     = mul_p;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        priority if (e_q == '0) begin
          state_d = ST_DONE;
        end else if (e_q[0]) begin
          mul_start = 1'b1;
          mul_a     = acc_q;
          state_d   = ST_MULA;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_SQR;
        end
      end
      ST_MULA: begin
        if (mul_done) begin
          acc_d = mul_p;
          if (e_q[EXP_W-1:1] == '0) begin
            // last set bit: the trailing square is not needed
            state_d = ST_DONE;
          end else begin
            mul_start = 1'b1;
            state_d   = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          b_d     = mul_p;
          e_d     = e_q >> 1;
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !m_axis_tready) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= MOD_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        modulus_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    if (load) begin
      res_q <= acc_q;
    end
  end

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (modulus_q),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(res_q);

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE) else $error("request taken but core stayed idle");

  a_result_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !mod_lt2) |-> acc_q < modulus_q) else $error("result not below modulus");

  a_done_when_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_RED || state_q == ST_MULA || state_q == ST_SQR))
    else $error("multiplier finished with no one waiting");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for modular_exponent_and_inverse_core, power and inverse
// requests checked against a local square-and-multiply predictor. Depends on mexp_pkg.
module tb_top;
  import mexp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned TAIL_CYCLES = 4500;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 33;

  typedef logic [EXP_BITS-1:0] expo_t;

  typedef enum logic [1:0] {REQ_ITEM, REQ_CONFIG, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e kind;
    logic      action;
    mod_t      base;
    expo_t     exponent;
    mod_t      modulus;
  } pend_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // base, exponent, zero pad
  logic                  s_axis_tuser = ACT_POWER;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // result, zero pad
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  mod_t                  cfg_data_i = MOD_RESET;

  pend_req_t pending_reqs[$];
  mod_t      expected_powers[$];
  pend_req_t cur_req;
  mod_t      model_modulus = MOD_RESET;

  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned modulus_writes = 0;
  int unsigned inverse_sent = 0;
  int unsigned error_count = 0;
  bit          timed_out = 1'b0;

  // sender burst state
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic        nxt_valid;
  logic        nxt_cfg_valid;
  logic [IN_DATA_W-1:0] nxt_tdata;

  // receiver stall pattern
  int unsigned rdy_left = 0;
  mod_t        want;

  modular_exponent_and_inverse_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // right-to-left square-and-multiply; products of two 31-bit residues fit in 64 bits
  function automatic mod_t modpow_predict(logic action, mod_t base, expo_t exponent,
                                          mod_t modulus);
    longint unsigned m;
    longint unsigned b;
    longint unsigned e;
    longint unsigned acc;
    m = modulus;
    b = base;
    e = exponent;
    if (action == ACT_INVERSE) begin
      if (m < 2) return mod_t'(1);
      e = m - 2;
    end
    if (e == 0) return mod_t'(1);
    if (m < 2) return mod_t'(0);
    b = b % m;
    acc = 1;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      e = e >> 1;
      b = (b * b) % m;
    end
    return mod_t'(acc);
  endfunction

  task automatic push_item(logic action, mod_t base, expo_t exponent);
    pend_req_t r;
    r.kind = REQ_ITEM;
    r.action = action;
    r.base = base;
    r.exponent = exponent;
    r.modulus = '0;
    pending_reqs.push_back(r);
  endtask

  task automatic push_modulus(mod_t modulus);
    pend_req_t r;
    r.kind = REQ_CONFIG;
    r.action = ACT_POWER;
    r.base = '0;
    r.exponent = '0;
    r.modulus = modulus;
    pending_reqs.push_back(r);
  endtask

  task automatic push_drain();
    pend_req_t r;
    r.kind = REQ_DRAIN;
    r.action = ACT_POWER;
    r.base = '0;
    r.exponent = '0;
    r.modulus = '0;
    pending_reqs.push_back(r);
  endtask

  // driver: one request at a time from pending_reqs, items sent in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= ACT_POWER;
      cfg_valid_i <= 1'b0;
      cfg_data_i <= MOD_RESET;
      model_modulus = MOD_RESET;
      burst_left = 0;
      gap_left = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_cfg_valid = cfg_valid_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_powers.push_back(modpow_predict(cur_req.action, cur_req.base,
                                                 cur_req.exponent, model_modulus));
        items_sent++;
        if (cur_req.action == ACT_INVERSE) inverse_sent++;
        nxt_valid = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        model_modulus = cfg_data_i;
        modulus_writes++;
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_valid && !nxt_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          case (pending_reqs[0].kind)
            REQ_ITEM: begin
              cur_req = pending_reqs.pop_front();
              nxt_tdata = '0;
              nxt_tdata[MOD_BITS-1:0] = cur_req.base;
              nxt_tdata[MOD_BITS +: EXP_BITS] = cur_req.exponent;
              s_axis_tdata <= nxt_tdata;
              s_axis_tuser <= cur_req.action;
              nxt_valid = 1'b1;
              if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
              end
            end
            REQ_CONFIG: begin
              // modulus only changes once the core has nothing left to deliver
              if (expected_powers.size() == 0) begin
                cfg_data_i <= pending_reqs[0].modulus;
                nxt_cfg_valid = 1'b1;
                void'(pending_reqs.pop_front());
              end
            end
            default: begin
              if (expected_powers.size() == 0) void'(pending_reqs.pop_front());
            end
          endcase
        end
      end
      s_axis_tvalid <= nxt_valid;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // monitor: compare each delivered result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_powers.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: expected none actual %0d", $time, m_axis_tdata);
        end else begin
          want = expected_powers.pop_front();
          results_checked++;
          if (m_axis_tdata !== OUT_DATA_W'(want)) begin
            error_count++;
            $display("%0t result mismatch: expected %0d actual %0d", $time, want,
                     m_axis_tdata);
          end
        end
      end
      if (rdy_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          m_axis_tready <= 1'b0;
          rdy_left = $urandom_range(1, 25);
        end else begin
          m_axis_tready <= 1'b1;
          rdy_left = $urandom_range(1, 60);
        end
      end else begin
        rdy_left--;
      end
    end
  end

  initial begin
    mod_t            m;
    mod_t            b;
    expo_t           e;
    logic            act;
    int unsigned     w;
    int unsigned     pick;
    longint unsigned mult;

    // directed: reset modulus 2^31-1
    push_item(ACT_POWER, 31'd0, '0);
    push_item(ACT_POWER, 31'd0, 63'd5);
    push_item(ACT_POWER, 31'h7fff_ffff, 63'd3);
    push_item(ACT_POWER, 31'h7fff_fffe, 63'h7fff_ffff_ffff_ffff);
    push_item(ACT_POWER, 31'd2, 63'd1);
    push_item(ACT_POWER, 31'd3, 63'h4000_0000_0000_0000);
    push_item(ACT_INVERSE, 31'd12345, EXP_BITS'({$urandom, $urandom}));
    push_item(ACT_INVERSE, 31'd0, 63'h7fff_ffff_ffff_ffff);
    push_item(ACT_INVERSE, 31'd1, '0);
    push_item(ACT_INVERSE, 31'h7fff_ffff, 63'd17);
    push_item(ACT_POWER, 31'd1, 63'h7fff_ffff_ffff_ffff);
    push_drain();
    // modulus of one
    push_modulus(31'd1);
    push_item(ACT_POWER, 31'd5, '0);
    push_item(ACT_POWER, 31'd5, 63'd9);
    push_item(ACT_INVERSE, 31'd7, 63'd3);
    push_item(ACT_POWER, 31'h7fff_ffff, 63'h7fff_ffff_ffff_ffff);
    // modulus two: inverse exponent is zero
    push_modulus(31'd2);
    push_item(ACT_INVERSE, 31'd1, '0);
    push_item(ACT_POWER, 31'd3, 63'd7);
    push_item(ACT_POWER, 31'd2, 63'd1);
    push_modulus(31'd3);
    push_item(ACT_INVERSE, 31'd2, 63'h7fff_ffff_ffff_ffff);
    push_item(ACT_INVERSE, 31'd3, '0);
    // composite modulus at the top of the range
    push_modulus(31'h7fff_fffe);
    push_item(ACT_INVERSE, 31'd3, '0);
    push_item(ACT_POWER, 31'h7fff_ffff, 63'd2);
    push_item(ACT_POWER, 31'd12345678, 63'h5555_5555_5555_5555);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: m = 31'h7fff_ffff;
        1: m = 31'd1000000007;
        2: m = 31'd65521;
        3: m = mod_t'($urandom_range(2, 32'h7fff_ffff));
        4: m = 31'd3;
        5: m = 31'd1;
        6: m = mod_t'($urandom_range(1, 1000));
        default: m = 31'd251;
      endcase
      push_modulus(m);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        act = ($urandom_range(0, 3) == 0) ? ACT_INVERSE : ACT_POWER;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          b = '0;
        end else if (pick == 1) begin
          b = 31'h7fff_ffff;
        end else if (pick == 2) begin
          mult = longint'(m) * $urandom_range(0, 32'h7fff_ffff / m);
          b = mod_t'(mult);
        end else begin
          b = mod_t'($urandom);
        end
        pick = $urandom_range(0, 5);
        e = EXP_BITS'({$urandom, $urandom});
        if (pick == 0) begin
          e = '0;
        end else if (pick != 1) begin
          // mostly short exponents to keep the run length down
          w = $urandom_range(1, 20);
          e = e & ((expo_t'(1) << w) - expo_t'(1));
        end
        push_item(act, b, e);
        if ($urandom_range(0, 29) == 0) push_drain();
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && (pending_reqs.size() != 0 || s_axis_tvalid || cfg_valid_i ||
                          expected_powers.size() != 0)) begin
      @(posedge clk_i);
      if (cycle_count >= CYCLE_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_powers.size());
    end else begin
      // catch any stray result that shows up late
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (expected_powers.size() != 0) error_count++;
    end

    $display("sent %0d requests (%0d inverse) over %0d modulus settings", items_sent,
             inverse_sent, modulus_writes);
    $display("checked %0d results, %0d errors, %0d cycles", results_checked, error_count,
             cycle_count);
    if (error_count == 0 && !timed_out) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
